@@ rtl/two_level_weighted_matrix_sampler_assert.svh @@
// assertion macros for the two-level weighted matrix sampler checker
// no dependencies; included by the checker file
`ifndef TWO_LEVEL_WEIGHTED_MATRIX_SAMPLER_ASSERT_SVH
`define TWO_LEVEL_WEIGHTED_MATRIX_SAMPLER_ASSERT_SVH

// same-cycle implication
`define TLWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlws: same-cycle check failed");

// next-cycle implication
`define TLWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlws: next-cycle check failed");

`endif

@@ rtl/tlws_pkg.sv @@
// shared types and constants for the two-level weighted matrix sampler
// no dependencies
package tlws_pkg;

    localparam int FRAC_W   = 16;
    localparam int IDX_W    = 4;
    localparam int WVAL_W   = 16;
    localparam int STATUS_W = 2;

    localparam int DEF_NUM_ROWS    = 16;
    localparam int DEF_NUM_COLS    = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WRITE = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [WVAL_W-1:0] weight_value;
        logic [FRAC_W-1:0] rand_row_frac;
        logic [FRAC_W-1:0] rand_col_frac;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]    chosen_row;
        logic [IDX_W-1:0]    chosen_col;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic wgt_rd;
        logic wgt_wr;
        logic sum_rd;
        logic sum_wr;
    } mem_ctl_t;

endpackage

@@ rtl/tlws_store.sv @@
// weight memory and row-sum memory, one read-or-write port each, registered read data
// depends on tlws_pkg
module tlws_store #(
    parameter int NUM_ROWS    = tlws_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS    = tlws_pkg::DEF_NUM_COLS,
    parameter int WEIGHT_BITS = tlws_pkg::DEF_WEIGHT_BITS,
    localparam int CELLS   = NUM_ROWS * NUM_COLS,
    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int SUM_W   = WEIGHT_BITS + $clog2(NUM_COLS)
) (
    input  logic                   clk,
    input  tlws_pkg::mem_ctl_t     ctl,
    input  logic [CELL_AW-1:0]     wgt_addr,
    input  logic [WEIGHT_BITS-1:0] wgt_wdata,
    output logic [WEIGHT_BITS-1:0] wgt_rdata,
    input  logic [ROW_AW-1:0]      sum_addr,
    input  logic [SUM_W-1:0]       sum_wdata,
    output logic [SUM_W-1:0]       sum_rdata
);
    import tlws_pkg::*;

    logic [WEIGHT_BITS-1:0] wgt_mem [CELLS];
    logic [SUM_W-1:0]       sum_mem [NUM_ROWS];
    logic [WEIGHT_BITS-1:0] wgt_rdata_reg;
    logic [SUM_W-1:0]       sum_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wgt_wr)
        begin
            wgt_mem[wgt_addr] <= wgt_wdata;
        end
        if (ctl.wgt_rd)
        begin
            wgt_rdata_reg <= wgt_mem[wgt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_wr)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        if (ctl.sum_rd)
        begin
            sum_rdata_reg <= sum_mem[sum_addr];
        end
    end

    assign wgt_rdata = wgt_rdata_reg;
    assign sum_rdata = sum_rdata_reg;

endmodule

@@ rtl/tlws_ctrl.sv @@
// sequencer: clearing pass, weight update, row and column scans, response register
// depends on tlws_pkg; drives tlws_store
module tlws_ctrl #(
    parameter int NUM_ROWS    = tlws_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS    = tlws_pkg::DEF_NUM_COLS,
    parameter int WEIGHT_BITS = tlws_pkg::DEF_WEIGHT_BITS,
    localparam int CELLS   = NUM_ROWS * NUM_COLS,
    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int SUM_W   = WEIGHT_BITS + $clog2(NUM_COLS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tlws_pkg::req_t         req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output tlws_pkg::rsp_t         rsp,
    output tlws_pkg::mem_ctl_t     ctl,
    output logic [CELL_AW-1:0]     wgt_addr,
    output logic [WEIGHT_BITS-1:0] wgt_wdata,
    input  logic [WEIGHT_BITS-1:0] wgt_rdata,
    output logic [ROW_AW-1:0]      sum_addr,
    output logic [SUM_W-1:0]       sum_wdata,
    input  logic [SUM_W-1:0]       sum_rdata
);
    import tlws_pkg::*;

    localparam int TOT_W  = SUM_W + $clog2(NUM_ROWS);
    localparam int PROD_W = FRAC_W + TOT_W;
    localparam int SCAN_N = (NUM_ROWS > NUM_COLS) ? NUM_ROWS : NUM_COLS;
    localparam int SCAN_W = $clog2(SCAN_N + 1);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_WR_UPD   = 3'd2;
    localparam logic [2:0] S_ROW_MUL  = 3'd3;
    localparam logic [2:0] S_ROW_SCAN = 3'd4;
    localparam logic [2:0] S_COL_MUL  = 3'd5;
    localparam logic [2:0] S_COL_SCAN = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam rsp_t RSP_WRITE = '{chosen_row: '0, chosen_col: '0, status: STATUS_WRITE};
    localparam rsp_t RSP_EMPTY = '{chosen_row: '0, chosen_col: '0, status: STATUS_EMPTY};

    logic [2:0]       state_reg,   state_next;
    logic [CELL_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [TOT_W-1:0] total_reg,   total_next;
    req_t             item_reg,    item_next;
    logic [TOT_W-1:0] draw_reg,    draw_next;
    logic [TOT_W-1:0] acc_reg,     acc_next;
    logic [SCAN_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SCAN_W-1:0] chk_idx_reg, chk_idx_next;
    logic             dv_reg,      dv_next;
    logic [ROW_AW-1:0] row_reg,    row_next;
    logic [SUM_W-1:0] rsum_reg,    rsum_next;
    logic [CELL_AW-1:0] base_reg,  base_next;
    rsp_t             res_reg,     res_next;
    rsp_t             rsp_reg,     rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]       cell_row;
    logic [IDX_W-1:0]       cell_col;
    logic [31:0]            cell_full;
    logic [31:0]            row_full;
    logic                   req_in_range;
    logic [31:0]            wv_ext;
    logic [WEIGHT_BITS-1:0] wval;
    logic                   clr_in_rows;
    logic [FRAC_W-1:0]      mul_a;
    logic [TOT_W-1:0]       mul_b;
    logic [PROD_W-1:0]      prod;
    logic [TOT_W-1:0]       scan_val;
    logic [TOT_W-1:0]       acc_sum;
    logic                   hit;
    logic [31:0]            chk_ext;
    logic [31:0]            rd_ext;
    logic [31:0]            row_ext;
    logic [31:0]            row_base_full;
    logic [31:0]            scan_cell_full;

    // address of the weight being written, from the request or the held item
    assign cell_row  = (state_reg == S_IDLE) ? req.row_index : item_reg.row_index;
    assign cell_col  = (state_reg == S_IDLE) ? req.col_index : item_reg.col_index;
    assign cell_full = 32'(cell_row) * 32'(NUM_COLS) + 32'(cell_col);
    assign row_full  = 32'(cell_row);

    assign req_in_range = (32'(req.row_index) < NUM_ROWS) && (32'(req.col_index) < NUM_COLS);

    assign wv_ext = 32'(item_reg.weight_value);
    assign wval   = wv_ext[WEIGHT_BITS-1:0];

    assign clr_in_rows = 32'(clr_cnt_reg) < NUM_ROWS;

    // shared scaling multiplier
    assign mul_a = (state_reg == S_ROW_MUL) ? item_reg.rand_row_frac : item_reg.rand_col_frac;
    assign mul_b = (state_reg == S_ROW_MUL) ? total_reg : TOT_W'(rsum_reg);
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign scan_val = (state_reg == S_ROW_SCAN) ? TOT_W'(sum_rdata) : TOT_W'(wgt_rdata);
    assign acc_sum  = acc_reg + scan_val;
    assign hit      = (draw_reg >= acc_reg) && (draw_reg < acc_sum);

    assign chk_ext        = 32'(chk_idx_reg);
    assign rd_ext         = 32'(rd_idx_reg);
    assign row_ext        = 32'(row_reg);
    assign row_base_full  = row_ext * 32'(NUM_COLS);
    assign scan_cell_full = 32'(base_reg) + rd_ext;

    always_comb
    begin
        case (state_reg)
            S_CLEAR:    wgt_addr = clr_cnt_reg;
            S_COL_SCAN: wgt_addr = scan_cell_full[CELL_AW-1:0];
            default:    wgt_addr = cell_full[CELL_AW-1:0];
        endcase
        case (state_reg)
            S_CLEAR:    sum_addr = clr_cnt_reg[ROW_AW-1:0];
            S_ROW_SCAN: sum_addr = rd_ext[ROW_AW-1:0];
            default:    sum_addr = row_full[ROW_AW-1:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        total_next     = total_reg;
        item_next      = item_reg;
        draw_next      = draw_reg;
        acc_next       = acc_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        dv_next        = 1'b0;
        row_next       = row_reg;
        rsum_next      = rsum_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;
        wgt_wdata      = '0;
        sum_wdata      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ctl.wgt_wr = 1'b1;
                ctl.sum_wr = clr_in_rows;
                if (clr_cnt_reg == CELL_AW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CELL_AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    if (req.mode == MODE_WRITE)
                    begin
                        if (req_in_range)
                        begin
                            ctl.wgt_rd = 1'b1;
                            ctl.sum_rd = 1'b1;
                            state_next = S_WR_UPD;
                        end
                        else
                        begin
                            res_next   = RSP_WRITE;
                            state_next = S_DONE;
                        end
                    end
                    else if (total_reg == '0)
                    begin
                        res_next   = RSP_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROW_MUL;
                    end
                end
            end

            S_WR_UPD:
            begin
                ctl.wgt_wr = 1'b1;
                ctl.sum_wr = 1'b1;
                wgt_wdata  = wval;
                sum_wdata  = sum_rdata - SUM_W'(wgt_rdata) + SUM_W'(wval);
                total_next = total_reg - TOT_W'(wgt_rdata) + TOT_W'(wval);
                res_next   = RSP_WRITE;
                state_next = S_DONE;
            end

            S_ROW_MUL:
            begin
                draw_next   = prod[PROD_W-1:FRAC_W];
                acc_next    = '0;
                rd_idx_next = '0;
                state_next  = S_ROW_SCAN;
            end

            S_ROW_SCAN:
            begin
                if (rd_ext < NUM_ROWS)
                begin
                    ctl.sum_rd   = 1'b1;
                    rd_idx_next  = rd_idx_reg + SCAN_W'(1);
                    chk_idx_next = rd_idx_reg;
                    dv_next      = 1'b1;
                end
                if (dv_reg)
                begin
                    if (hit)
                    begin
                        row_next   = chk_ext[ROW_AW-1:0];
                        rsum_next  = sum_rdata;
                        state_next = S_COL_MUL;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        if (chk_idx_reg == SCAN_W'(NUM_ROWS - 1))
                        begin
                            res_next   = RSP_EMPTY;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_COL_MUL:
            begin
                draw_next   = prod[PROD_W-1:FRAC_W];
                acc_next    = '0;
                rd_idx_next = '0;
                base_next   = row_base_full[CELL_AW-1:0];
                state_next  = S_COL_SCAN;
            end

            S_COL_SCAN:
            begin
                if (rd_ext < NUM_COLS)
                begin
                    ctl.wgt_rd   = 1'b1;
                    rd_idx_next  = rd_idx_reg + SCAN_W'(1);
                    chk_idx_next = rd_idx_reg;
                    dv_next      = 1'b1;
                end
                if (dv_reg)
                begin
                    if (hit)
                    begin
                        res_next.chosen_row = row_ext[IDX_W-1:0];
                        res_next.chosen_col = chk_ext[IDX_W-1:0];
                        res_next.status     = STATUS_OK;
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        if (chk_idx_reg == SCAN_W'(NUM_COLS - 1))
                        begin
                            res_next   = RSP_EMPTY;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            dv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            dv_reg        <= dv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        draw_reg    <= draw_next;
        acc_reg     <= acc_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        row_reg     <= row_next;
        rsum_reg    <= rsum_next;
        base_reg    <= base_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/two_level_weighted_matrix_sampler.sv @@
// two-level weighted matrix sampler: top level, tlws_ctrl plus tlws_store, uses tlws_pkg
// write: the request passes S_WR_UPD, then S_DONE, which registers the response;
//   a write out of range or a sample of an empty matrix goes straight to S_DONE
// sample: S_ROW_MUL, S_ROW_SCAN, S_COL_MUL, S_COL_SCAN, then S_DONE; req_ready returns
//   high together with rsp_valid; one row-sum then one weight read a cycle
// reset: clears all NUM_ROWS * NUM_COLS cells (256 at default) and row sums, req_ready low
module two_level_weighted_matrix_sampler #(
    parameter int NUM_ROWS    = tlws_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS    = tlws_pkg::DEF_NUM_COLS,
    parameter int WEIGHT_BITS = tlws_pkg::DEF_WEIGHT_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tlws_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tlws_pkg::rsp_t rsp
);
    import tlws_pkg::*;

    localparam int CELLS   = NUM_ROWS * NUM_COLS;
    localparam int ROW_AW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SUM_W   = WEIGHT_BITS + $clog2(NUM_COLS);

    mem_ctl_t               ctl;
    logic [CELL_AW-1:0]     wgt_addr;
    logic [WEIGHT_BITS-1:0] wgt_wdata;
    logic [WEIGHT_BITS-1:0] wgt_rdata;
    logic [ROW_AW-1:0]      sum_addr;
    logic [SUM_W-1:0]       sum_wdata;
    logic [SUM_W-1:0]       sum_rdata;

    tlws_ctrl #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLS    (NUM_COLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ctl       (ctl),
        .wgt_addr  (wgt_addr),
        .wgt_wdata (wgt_wdata),
        .wgt_rdata (wgt_rdata),
        .sum_addr  (sum_addr),
        .sum_wdata (sum_wdata),
        .sum_rdata (sum_rdata)
    );

    tlws_store #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLS    (NUM_COLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_store (
        .clk       (clk),
        .ctl       (ctl),
        .wgt_addr  (wgt_addr),
        .wgt_wdata (wgt_wdata),
        .wgt_rdata (wgt_rdata),
        .sum_addr  (sum_addr),
        .sum_wdata (sum_wdata),
        .sum_rdata (sum_rdata)
    );

endmodule

@@ rtl/tlws_checker.sv @@
// port-level checks for the two-level weighted matrix sampler, bound to the top level
// depends on tlws_pkg and two_level_weighted_matrix_sampler_assert.svh
`include "two_level_weighted_matrix_sampler_assert.svh"

module tlws_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input tlws_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tlws_pkg::rsp_t rsp
);
    import tlws_pkg::*;

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // writes and failed samples carry no position
    `TLWS_ASSERT_SAME(a_no_pos_on_fail, clk, rst_n, rsp_valid && rsp.status != STATUS_OK, rsp.chosen_row == '0 && rsp.chosen_col == '0)

    // one request in flight at a time
    `TLWS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_fire, !req_ready)

    // no response appears on the cycle right after a request is taken
    `TLWS_ASSERT_NEXT(a_no_instant_rsp, clk, rst_n, req_fire, !$rose(rsp_valid))

    `TLWS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind two_level_weighted_matrix_sampler tlws_checker u_tlws_checker (.*);
